// ===== rtl/rc4fb_pkg.sv =====
// Shared constants and types for the RC4 feedback stream cipher.
// No dependencies; imported by the cipher core and its port checker.
package rc4fb_pkg;

  localparam int KEY_MAX = 32;
  localparam int KEY_AW  = $clog2(KEY_MAX);
  localparam int KCW     = $clog2(KEY_MAX + 1);

  typedef enum logic [1:0] {
    OP_KEY = 2'd0,
    OP_ENC = 2'd1,
    OP_DEC = 2'd2,
    OP_NOP = 2'd3
  } opcode_t;

endpackage

// ===== rtl/rc4_feedback_stream_cipher.sv =====
// RC4 stream cipher with plaintext feedback: key buffer, key schedule and generator.
// Depends on rc4fb_pkg.
//
// Usage: one input channel (in_valid / in_stall) carries opcode, data byte and
// last-key mark; one result channel (out_valid / out_stall) carries out_byte.
// Key words (opcode 0) are stored in a 32-entry key buffer; extra key words
// beyond the buffer are dropped. A key word with last_key set runs the key
// schedule: 256 steps over the permutation memory (read S[i], read S[j], two
// swap writes) with in_stall high, after which the indices clear and feedback
// takes the first key word.
// Encrypt and decrypt words keep in_stall high from acceptance until the
// result is loaded into the output register; loading waits while a stalled
// result is still held. The five permutation accesses per word (read i, read
// j, two swap writes, one more read) each depend on the one before. Opcode 3
// is a no-op.
// Results sit in an output register; a new word is accepted while a result
// waits, and the generator holds its last step until the receiver drops
// out_stall. Reset (rst_n low, synchronous) restores the identity
// permutation through per-entry valid bits, clears indices, feedback and
// the key count, and empties the output register.
module rc4_feedback_stream_cipher
  import rc4fb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_key,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_D_SI = 10'b00_0000_0010,
    ST_D_SJ = 10'b00_0000_0100,
    ST_D_WJ = 10'b00_0000_1000,
    ST_D_RT = 10'b00_0001_0000,
    ST_D_OUT = 10'b00_0010_0000,
    ST_K_RD = 10'b00_0100_0000,
    ST_K_SI = 10'b00_1000_0000,
    ST_K_SJ = 10'b01_0000_0000,
    ST_K_WJ = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]        step_r, step_nxt;
  logic [7:0]        mix_r, mix_nxt;
  logic [7:0]        fb_r, fb_nxt;
  logic [KCW-1:0]    key_count_r, key_count_nxt;
  logic [7:0]        first_key_r, first_key_nxt;
  logic [7:0]        i_r, i_nxt;
  logic [7:0]        j_r, j_nxt;
  logic [KEY_AW-1:0] kidx_r, kidx_nxt;
  logic [7:0]        si_r, si_nxt;
  logic [7:0]        sj_r, sj_nxt;
  logic [7:0]        data_r, data_nxt;
  logic              dec_r, dec_nxt;
  logic [255:0]      valid_r, valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;

  // permutation memory, one read and one write port
  logic [7:0] perm_mem [256];
  logic [7:0] perm_rd_addr;
  logic       perm_we;
  logic [7:0] perm_wa;
  logic [7:0] perm_wd;
  logic [7:0] pq_r;
  logic       pv_r;
  logic [7:0] pa_r;
  logic [7:0] perm_rd;

  // key buffer
  logic [7:0]        key_mem [KEY_MAX];
  logic              key_we;
  logic [KEY_AW-1:0] key_wa;
  logic [7:0]        key_q_r;

  logic in_acc;
  logic out_acc;
  logic [7:0] res;

  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[perm_wa] <= perm_wd;
    end
    pq_r <= perm_mem[perm_rd_addr];
    pv_r <= valid_r[perm_rd_addr];
    pa_r <= perm_rd_addr;
  end

  // an entry never written since the last clear reads as its own index
  assign perm_rd = pv_r ? pq_r : pa_r;

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= in_data_byte;
    end
    key_q_r <= key_mem[kidx_r];
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_acc   = out_valid_r && !out_stall;
  assign res       = data_r ^ perm_rd ^ fb_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    mix_nxt       = mix_r;
    fb_nxt        = fb_r;
    key_count_nxt = key_count_r;
    first_key_nxt = first_key_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    kidx_nxt      = kidx_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    data_nxt      = data_r;
    dec_nxt       = dec_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_acc ? 1'b0 : out_valid_r;
    out_byte_nxt  = out_byte_r;
    perm_rd_addr  = step_r + 8'd1;
    perm_we       = 1'b0;
    perm_wa       = i_r;
    perm_wd       = perm_rd;
    key_we        = 1'b0;
    key_wa        = key_count_r[KEY_AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (opcode_t'(in_opcode))
            OP_KEY: begin
              if (key_count_r < KCW'(KEY_MAX)) begin
                key_we        = 1'b1;
                key_count_nxt = key_count_r + KCW'(1);
                if (key_count_r == '0) begin
                  first_key_nxt = in_data_byte;
                end
              end
              if (in_last_key) begin
                valid_nxt = '0;
                i_nxt     = 8'd0;
                j_nxt     = 8'd0;
                kidx_nxt  = '0;
                state_nxt = ST_K_RD;
              end
            end
            OP_ENC, OP_DEC: begin
              // read S[i] with i = step + 1 this cycle
              step_nxt  = step_r + 8'd1;
              data_nxt  = in_data_byte;
              dec_nxt   = (opcode_t'(in_opcode) == OP_DEC);
              state_nxt = ST_D_SI;
            end
            default: ;
          endcase
        end
      end
      ST_D_SI: begin
        si_nxt       = perm_rd;
        mix_nxt      = mix_r + perm_rd;
        perm_rd_addr = mix_r + perm_rd;
        state_nxt    = ST_D_SJ;
      end
      ST_D_SJ: begin
        sj_nxt    = perm_rd;
        perm_we   = 1'b1;
        perm_wa   = step_r;
        perm_wd   = perm_rd;
        state_nxt = ST_D_WJ;
      end
      ST_D_WJ: begin
        perm_we   = 1'b1;
        perm_wa   = mix_r;
        perm_wd   = si_r;
        state_nxt = ST_D_RT;
      end
      ST_D_RT: begin
        perm_rd_addr = si_r + sj_r;
        state_nxt    = ST_D_OUT;
      end
      ST_D_OUT: begin
        // hold the keystream byte until the output register frees up
        perm_rd_addr = pa_r;
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = res;
          fb_nxt        = fb_r ^ (dec_r ? res : data_r);
          state_nxt     = ST_IDLE;
        end
      end
      ST_K_RD: begin
        perm_rd_addr = i_r;
        state_nxt    = ST_K_SI;
      end
      ST_K_SI: begin
        si_nxt       = perm_rd;
        j_nxt        = j_r + key_q_r + perm_rd;
        perm_rd_addr = j_r + key_q_r + perm_rd;
        state_nxt    = ST_K_SJ;
      end
      ST_K_SJ: begin
        perm_we   = 1'b1;
        perm_wa   = i_r;
        perm_wd   = perm_rd;
        state_nxt = ST_K_WJ;
      end
      ST_K_WJ: begin
        perm_we = 1'b1;
        perm_wa = j_r;
        perm_wd = si_r;
        i_nxt   = i_r + 8'd1;
        // walk the key cyclically over the held bytes
        if (KCW'(kidx_r) + KCW'(1) == key_count_r) begin
          kidx_nxt = '0;
        end else begin
          kidx_nxt = kidx_r + KEY_AW'(1);
        end
        if (i_r == 8'hff) begin
          fb_nxt        = first_key_r;
          step_nxt      = 8'd0;
          mix_nxt       = 8'd0;
          key_count_nxt = '0;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_K_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (perm_we) begin
      valid_nxt[perm_wa] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 8'd0;
      mix_r       <= 8'd0;
      fb_r        <= 8'd0;
      key_count_r <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      mix_r       <= mix_nxt;
      fb_r        <= fb_nxt;
      key_count_r <= key_count_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_key_r <= first_key_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    kidx_r      <= kidx_nxt;
    si_r        <= si_nxt;
    sj_r        <= sj_nxt;
    data_r      <= data_nxt;
    dec_r       <= dec_nxt;
    out_byte_r  <= out_byte_nxt;
  end

endmodule

// ===== rtl/rc4fb_checker.sv =====
// Port-level checker for the RC4 feedback stream cipher, bound to its top level.
// Depends on rc4fb_pkg and rc4_feedback_stream_cipher.
module rc4fb_checker
  import rc4fb_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_opcode,
  input logic       in_last_key,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte
);

  logic in_acc;
  logic data_acc;
  logic key_acc;

  assign in_acc   = in_valid && !in_stall;
  assign data_acc = in_acc && (in_opcode == OP_ENC || in_opcode == OP_DEC);
  assign key_acc  = in_acc && (in_opcode == OP_KEY);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte))
    else $error("result word changed while stalled");

  // data words and the key schedule keep the input side busy
  a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
    data_acc |=> in_stall)
    else $error("input not stalled after data word");

  a_sched_busy: assert property (@(posedge clk) disable iff (!rst_n)
    key_acc && in_last_key |=> in_stall)
    else $error("input not stalled after last key word");

  // key words never produce a result
  a_key_silent: assert property (@(posedge clk) disable iff (!rst_n)
    key_acc && !out_valid |=> !out_valid)
    else $error("result word after key word");

  // a result only appears at the end of generator work
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word without generator work");

endmodule

bind rc4_feedback_stream_cipher rc4fb_checker u_rc4fb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_opcode   (in_opcode),
  .in_last_key (in_last_key),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_byte    (out_byte)
);
